// ===== rtl/rsee_pkg.sv =====
// ============================================================================
// rsee_pkg: shared types, constants and effect tables
// Holds the status and command codes, colour constants, the register map and
// the intensity tables of the sine-shaped effects, built at elaboration.
// ============================================================================
`default_nettype none

package rsee_pkg;

  // Tick period of the effect time base and the effect periods, in ms.
  localparam int STEP_MS        = 20;
  localparam int LISTEN_PER_MS  = 1000;
  localparam int SPEAK_PER_MS   = 300;
  localparam int CONNECT_PER_MS = 2000;
  localparam int PROC_HALF_MS   = 500;
  localparam int ERROR_HALF_MS  = 200;

  // Phase counters run over ticks; each period is a whole number of ticks.
  localparam int LISTEN_N   = LISTEN_PER_MS / STEP_MS;
  localparam int SPEAK_N    = SPEAK_PER_MS / STEP_MS;
  localparam int CONNECT_N  = CONNECT_PER_MS / STEP_MS;
  localparam int ERROR_N    = (2 * ERROR_HALF_MS) / STEP_MS;
  localparam int PROC_HALF  = PROC_HALF_MS / STEP_MS;
  localparam int ERROR_HALF = ERROR_HALF_MS / STEP_MS;

  localparam int LISTEN_W  = $clog2(LISTEN_N);
  localparam int SPEAK_W   = $clog2(SPEAK_N);
  localparam int CONNECT_W = $clog2(CONNECT_N);
  localparam int ERROR_W   = $clog2(ERROR_N);

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int BRIGHT_W = 7;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;

  typedef enum logic [1:0] {
    REG_BRIGHT = 2'd0,
    REG_ENABLE = 2'd1,
    REG_INVERT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_STATUS = 2'd1,
    FUNC_CUSTOM = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_OFF     = 4'd0,
    ST_BOOT    = 4'd1,
    ST_IDLE    = 4'd2,
    ST_LISTEN  = 4'd3,
    ST_PROCESS = 4'd4,
    ST_SPEAK   = 4'd5,
    ST_ERROR   = 4'd6,
    ST_CONNECT = 4'd7,
    ST_OTA     = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } colour_t;

  typedef struct packed {
    logic    valid;
    colour_t colour;
  } colour_req_t;

  typedef struct packed {
    logic                enable;
    logic                invert;
    logic [BRIGHT_W-1:0] pct;
  } cfg_t;

  localparam colour_t COL_BLACK   = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
  localparam colour_t COL_BOOT    = '{r: 8'd255, g: 8'd180, b: 8'd0};
  localparam colour_t COL_IDLE    = '{r: 8'd0,   g: 8'd80,  b: 8'd0};
  localparam colour_t COL_PROC_HI = '{r: 8'd255, g: 8'd180, b: 8'd0};
  localparam colour_t COL_PROC_LO = '{r: 8'd50,  g: 8'd35,  b: 8'd0};
  localparam colour_t COL_ERROR   = '{r: 8'd255, g: 8'd0,   b: 8'd0};

  function automatic logic is_effect(input logic [3:0] code);
    return (code >= ST_LISTEN) && (code <= ST_OTA);
  endfunction

  // Sine in Q30 from an odd polynomial over the reduced quarter wave.
  localparam longint Q30_ONE   = 64'd1073741824;
  localparam longint LEVEL_DEN = 100 * Q30_ONE;
  localparam longint K1  = 64'd1686629713;
  localparam longint K3  = 64'd693598668;
  localparam longint K5  = 64'd85569306;
  localparam longint K7  = 64'd5026995;
  localparam longint K9  = 64'd172272;
  localparam longint K11 = 64'd3864;

  function automatic longint sine_q30(input longint m, input longint per);
    longint q;
    longint r;
    longint y;
    longint y2;
    longint p;
    int     i;
    q = 0;
    r = 4 * m;
    for (i = 0; i < 3; i++) begin
      if (r >= per) begin
        r = r - per;
        q = q + 1;
      end
    end
    // Restoring long division for the fraction of the quarter wave.
    y = 0;
    for (i = 0; i < 30; i++) begin
      r = r << 1;
      y = y << 1;
      if (r >= per) begin
        r = r - per;
        y = y + 1;
      end
    end
    if (q[0]) y = Q30_ONE - y;
    y2 = (y * y) >> 30;
    p = K11;
    p = K9 - ((p * y2) >> 30);
    p = K7 - ((p * y2) >> 30);
    p = K5 - ((p * y2) >> 30);
    p = K3 - ((p * y2) >> 30);
    p = K1 - ((p * y2) >> 30);
    p = (p * y) >> 30;
    return (q >= 2) ? -p : p;
  endfunction

  function automatic logic [7:0] level_of(input longint s, input longint base,
                                          input longint swing, input longint full);
    longint num;
    longint v;
    num = base * Q30_ONE + swing * s;
    if (num < 0) num = 0;
    v = (num * full) / LEVEL_DEN;
    if (v > full) v = full;
    return 8'(v);
  endfunction

  localparam int LUT_MAX = CONNECT_N;
  localparam int LUT_AW  = $clog2(LUT_MAX);
  typedef logic [LUT_MAX-1:0][7:0] lut_t;

  function automatic lut_t build_lut(input longint per, input int n, input longint base,
                                     input longint swing, input longint full);
    lut_t lut;
    int   j;
    lut = '0;
    for (j = 0; j < LUT_MAX; j++) begin
      if (j < n) begin
        lut[LUT_AW'(j)] = level_of(sine_q30(longint'(j) * STEP_MS, per), base, swing, full);
      end
    end
    return lut;
  endfunction

  localparam lut_t LISTEN_FULL = build_lut(LISTEN_PER_MS, LISTEN_N, 65, 35, 255);
  localparam lut_t SPEAK_FULL  = build_lut(SPEAK_PER_MS, SPEAK_N, 65, 35, 255);
  localparam lut_t OTA_FULL    = build_lut(SPEAK_PER_MS, SPEAK_N, 60, 40, 255);
  localparam lut_t CONN_R_FULL = build_lut(CONNECT_PER_MS, CONNECT_N, 60, 40, 180);
  localparam lut_t CONN_B_FULL = build_lut(CONNECT_PER_MS, CONNECT_N, 60, 40, 255);

  localparam logic [LISTEN_N-1:0][7:0]  LISTEN_LUT = LISTEN_FULL[LISTEN_N-1:0];
  localparam logic [SPEAK_N-1:0][7:0]   SPEAK_LUT  = SPEAK_FULL[SPEAK_N-1:0];
  localparam logic [SPEAK_N-1:0][7:0]   OTA_LUT    = OTA_FULL[SPEAK_N-1:0];
  localparam logic [CONNECT_N-1:0][7:0] CONN_R_LUT = CONN_R_FULL[CONNECT_N-1:0];
  localparam logic [CONNECT_N-1:0][7:0] CONN_B_LUT = CONN_B_FULL[CONNECT_N-1:0];

endpackage

`default_nettype wire

// ===== rtl/rsee_if.sv =====
// ============================================================================
// rsee_if: item channels of the status effect engine
// Command items in, duty items out, each with valid, ready and payload.
// ============================================================================
`default_nettype none

interface rsee_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] status_code;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, func, status_code, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, func, status_code, red_in, green_in, blue_in,
                output ready);
endinterface

interface rsee_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_duty;
  logic [7:0] green_duty;
  logic [7:0] blue_duty;

  modport source (output valid, red_duty, green_duty, blue_duty, input ready);
  modport sink (input valid, red_duty, green_duty, blue_duty, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb_status_effect_engine_core.sv =====
// ============================================================================
// rgb_status_effect_engine_core: status LED effect engine
// Turns status, tick and custom colour items into scaled RGB PWM duties.
// ============================================================================
//
//   channel    direction  handshake             payload
//   item_i     in         valid / ready         func, status_code, red_in,
//                                               green_in, blue_in
//   result_o   out        valid / ready         red_duty, green_duty, blue_duty
//   APB        in / out   psel, penable, pwrite paddr, pwdata, prdata, pready
//
// One item per cycle is accepted while the colour queue has room. An accepted item
// is written into the queue, then popped into the brightness product register and
// from there into the output register, which offers its result.
// Reset is asynchronous and active low; it clears status, run, phase, queue and
// pipeline valid flags and loads the register reset values. A stalled result holds
// its output register, and decode stalls once the QUEUE_DEPTH-entry queue fills.
//
`default_nettype none

module rgb_status_effect_engine_core
  import rsee_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  rsee_item_if.sink               item_i,
  rsee_result_if.source           result_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  // Register file. The clamped brightness is kept beside the raw value so
  // that the multiplier sees a settled operand.
  logic [BRIGHT_W-1:0] bright_q, bright_d;
  logic [BRIGHT_W-1:0] pct_q, pct_d;
  logic                enable_q, enable_d;
  logic                invert_q, invert_d;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    bright_d = bright_q;
    pct_d    = pct_q;
    enable_d = enable_q;
    invert_d = invert_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_BRIGHT: begin
          bright_d = pwdata[BRIGHT_W-1:0];
          // Settings above full scale behave as full scale.
          pct_d = (pwdata[BRIGHT_W-1:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[BRIGHT_W-1:0];
        end
        REG_ENABLE: enable_d = pwdata[0];
        REG_INVERT: invert_d = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BRIGHT: prdata = DATA_W'(bright_q);
      REG_ENABLE: prdata = DATA_W'(enable_q);
      REG_INVERT: prdata = DATA_W'(invert_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_MAX;
      pct_q    <= BRIGHT_MAX;
      enable_q <= 1'b1;
      invert_q <= 1'b0;
    end else begin
      bright_q <= bright_d;
      pct_q    <= pct_d;
      enable_q <= enable_d;
      invert_q <= invert_d;
    end
  end

  // Decode feeds raw colours into the queue; the back end scales them.
  colour_req_t push, head;
  logic        full, pop;
  cfg_t        cfg;

  assign cfg.enable = enable_q;
  assign cfg.invert = invert_q;
  assign cfg.pct    = pct_q;

  rsee_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .enable_i (enable_q),
    .full_i   (full),
    .push_o   (push)
  );

  rsee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  rsee_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .cfg_i    (cfg),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rsee_front.sv =====
// ============================================================================
// rsee_front: command decode and effect sequencing
// Accepts command items, keeps the status and effect phase, and issues the
// raw colour each item yields into the colour queue.
// ============================================================================
`default_nettype none

module rsee_front
  import rsee_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rsee_item_if.sink   item_i,
  input  wire logic   enable_i,
  input  wire logic   full_i,
  output colour_req_t push_o
);

  logic                 accept;
  logic [3:0]           mode_q, mode_d;
  logic                 run_q, run_d;
  logic [LISTEN_W-1:0]  c_listen_q, c_listen_d, c_listen_nx;
  logic [SPEAK_W-1:0]   c_speak_q, c_speak_d, c_speak_nx;
  logic [CONNECT_W-1:0] c_connect_q, c_connect_d, c_connect_nx;
  logic [ERROR_W-1:0]   c_error_q, c_error_d, c_error_nx;
  colour_t              tick_colour;

  assign item_i.ready = ~full_i;
  assign accept       = item_i.valid & ~full_i;

  // All phase counters restart together, so they stay one step count.
  assign c_listen_nx  = (c_listen_q == LISTEN_W'(LISTEN_N - 1)) ? '0 : c_listen_q + 1'b1;
  assign c_speak_nx   = (c_speak_q == SPEAK_W'(SPEAK_N - 1)) ? '0 : c_speak_q + 1'b1;
  assign c_connect_nx = (c_connect_q == CONNECT_W'(CONNECT_N - 1)) ? '0 : c_connect_q + 1'b1;
  assign c_error_nx   = (c_error_q == ERROR_W'(ERROR_N - 1)) ? '0 : c_error_q + 1'b1;

  always_comb begin
    tick_colour = COL_BLACK;
    unique case (mode_q)
      ST_LISTEN: tick_colour.b = LISTEN_LUT[c_listen_q];
      ST_PROCESS: begin
        tick_colour = (c_listen_q >= LISTEN_W'(PROC_HALF)) ? COL_PROC_LO : COL_PROC_HI;
      end
      ST_SPEAK: begin
        tick_colour.g = SPEAK_LUT[c_speak_q];
        tick_colour.b = SPEAK_LUT[c_speak_q];
      end
      ST_ERROR: begin
        tick_colour = (c_error_q >= ERROR_W'(ERROR_HALF)) ? COL_BLACK : COL_ERROR;
      end
      ST_CONNECT: begin
        tick_colour.r = CONN_R_LUT[c_connect_q];
        tick_colour.b = CONN_B_LUT[c_connect_q];
      end
      default: begin
        tick_colour.r = OTA_LUT[c_speak_q];
        tick_colour.g = OTA_LUT[c_speak_q];
        tick_colour.b = OTA_LUT[c_speak_q];
      end
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    run_d       = run_q;
    c_listen_d  = c_listen_q;
    c_speak_d   = c_speak_q;
    c_connect_d = c_connect_q;
    c_error_d   = c_error_q;
    push_o      = '0;
    if (accept) begin
      unique case (func_e'(item_i.func))
        FUNC_TICK: begin
          if (run_q && is_effect(mode_q)) begin
            push_o.valid  = 1'b1;
            push_o.colour = tick_colour;
            c_listen_d    = c_listen_nx;
            c_speak_d     = c_speak_nx;
            c_connect_d   = c_connect_nx;
            c_error_d     = c_error_nx;
          end
        end
        FUNC_STATUS: begin
          mode_d = item_i.status_code;
          if (!is_effect(item_i.status_code) && is_effect(mode_q)) run_d = 1'b0;
          if (!enable_i) begin
            // Disabled output still shows black for any status change.
            push_o.valid = 1'b1;
          end else begin
            unique case (status_e'(item_i.status_code))
              ST_OFF: begin
                run_d        = 1'b0;
                push_o.valid = 1'b1;
              end
              ST_BOOT: begin
                push_o.valid  = 1'b1;
                push_o.colour = COL_BOOT;
              end
              ST_IDLE: begin
                push_o.valid  = 1'b1;
                push_o.colour = COL_IDLE;
              end
              default: begin
                // An effect entered from a static status starts a fresh run.
                if (is_effect(item_i.status_code) && !is_effect(mode_q) && !run_q) begin
                  run_d       = 1'b1;
                  c_listen_d  = '0;
                  c_speak_d   = '0;
                  c_connect_d = '0;
                  c_error_d   = '0;
                end
              end
            endcase
          end
        end
        FUNC_CUSTOM: begin
          run_d           = 1'b0;
          mode_d          = ST_OFF;
          push_o.valid    = 1'b1;
          push_o.colour.r = item_i.red_in;
          push_o.colour.g = item_i.green_in;
          push_o.colour.b = item_i.blue_in;
        end
        FUNC_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ST_OFF;
      run_q       <= 1'b0;
      c_listen_q  <= '0;
      c_speak_q   <= '0;
      c_connect_q <= '0;
      c_error_q   <= '0;
    end else begin
      mode_q      <= mode_d;
      run_q       <= run_d;
      c_listen_q  <= c_listen_d;
      c_speak_q   <= c_speak_d;
      c_connect_q <= c_connect_d;
      c_error_q   <= c_error_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsee_queue.sv =====
// ============================================================================
// rsee_queue: colour request queue
// Small circular buffer between command decode and the output stages.
// ============================================================================
`default_nettype none

module rsee_queue
  import rsee_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  colour_req_t push_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output colour_req_t head_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  colour_t       mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign full_o        = (cnt_q == CW'(DEPTH));
  assign push          = push_i.valid & ~full_o;
  assign pop           = pop_i & (cnt_q != '0);
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.colour = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_i.colour;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsee_back.sv =====
// ============================================================================
// rsee_back: brightness scaling and duty output
// Drops colours blocked by the enable, scales by the brightness percentage,
// inverts when set and drives the registered duty item.
// ============================================================================
`default_nettype none

module rsee_back
  import rsee_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  colour_req_t head_i,
  output logic        pop_o,
  input  cfg_t        cfg_i,
  rsee_result_if.source result_o
);

  localparam int PROD_W      = 8 + BRIGHT_W;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int MUL_W       = PROD_W + RECIP_W;
  // floor(x / 100) equals (x * 5243) >> 19 for every product below 43690.
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  logic              out_free, a_free, keep;
  logic              a_valid_q, a_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [PROD_W-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [7:0]        red_q, green_q, blue_q;

  function automatic logic [7:0] scale(input logic [PROD_W-1:0] p, input logic inv);
    logic [MUL_W-1:0] m;
    logic [7:0]       q;
    m = MUL_W'(p) * MUL_W'(RECIP_100);
    q = m[RECIP_SHIFT +: 8];
    return inv ? ~q : q;
  endfunction

  assign out_free = ~out_valid_q | result_o.ready;
  assign a_free   = ~a_valid_q | out_free;
  assign pop_o    = head_i.valid & a_free;
  assign keep     = cfg_i.enable | (head_i.colour == COL_BLACK);

  assign a_valid_d   = a_free ? (pop_o & keep) : a_valid_q;
  assign out_valid_d = out_free ? a_valid_q : out_valid_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_r_q <= PROD_W'(head_i.colour.r) * PROD_W'(cfg_i.pct);
      prod_g_q <= PROD_W'(head_i.colour.g) * PROD_W'(cfg_i.pct);
      prod_b_q <= PROD_W'(head_i.colour.b) * PROD_W'(cfg_i.pct);
    end
    if (out_free && a_valid_q) begin
      red_q   <= scale(prod_r_q, cfg_i.invert);
      green_q <= scale(prod_g_q, cfg_i.invert);
      blue_q  <= scale(prod_b_q, cfg_i.invert);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.red_duty   = red_q;
  assign result_o.green_duty = green_q;
  assign result_o.blue_duty  = blue_q;

endmodule

`default_nettype wire

// ===== rtl/rsee_checker.sv =====
// ============================================================================
// rsee_checker: port-level checks for the status effect engine
// Watches the result channel and the register port of the top level.
// ============================================================================
`default_nettype none

module rsee_checker
  import rsee_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [7:0]        red_duty_i,
  input wire logic [7:0]        green_duty_i,
  input wire logic [7:0]        blue_duty_i,
  input wire logic              psel_i,
  input wire logic              penable_i,
  input wire logic              pwrite_i,
  input wire logic [ADDR_W-1:0] paddr_i,
  input wire logic [DATA_W-1:0] pwdata_i,
  input wire logic [DATA_W-1:0] prdata_i
);

  logic wr;
  assign wr = psel_i & penable_i & pwrite_i;

  // A waiting result keeps its duties until it is taken.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({red_duty_i, green_duty_i, blue_duty_i}))
    else $error("result changed while stalled");

  // No result is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // The enable register reads back what was written.
  a_enable_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && paddr_i[ADDR_W-1:2] == REG_ENABLE) ##1
      (paddr_i[ADDR_W-1:2] == REG_ENABLE && !wr) |->
      prdata_i == DATA_W'($past(pwdata_i[0])))
    else $error("enable read-back mismatch");

  // The brightness register reads back the raw value, not the clamped one.
  a_bright_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && paddr_i[ADDR_W-1:2] == REG_BRIGHT) ##1
      (paddr_i[ADDR_W-1:2] == REG_BRIGHT && !wr) |->
      prdata_i == DATA_W'($past(pwdata_i[BRIGHT_W-1:0])))
    else $error("brightness read-back mismatch");

endmodule

bind rgb_status_effect_engine_core rsee_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .red_duty_i   (result_o.red_duty),
  .green_duty_i (result_o.green_duty),
  .blue_duty_i  (result_o.blue_duty),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .paddr_i      (paddr),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata)
);

`default_nettype wire

// ===== dv/rgb_status_effect_engine_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_status_effect_engine_core_test: self-checking bench of the LED engine
// Drives tick, status and custom colour items with random gaps and result
// stalls. A scoreboard with its own model of the effect engine predicts every
// scaled duty item. The bench walks through several register settings over
// the configuration port.
// ----------------------------------------------------------------------------

module rgb_status_effect_engine_core_test;
  import rsee_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 160;
  localparam int DRAIN_CYCLES = 10;
  localparam int WRAP_MS      = 6000;

  // Scoreboard: holds its own copy of the engine state and registers, turns
  // every accepted item into the duty items it should cause and matches the
  // items leaving the block against them in order.
  class led_duty_tracker;
    logic [BRIGHT_W-1:0] bright_pct;
    bit                  out_en;
    bit                  invert;
    logic [3:0]          mode;
    int unsigned         step_count;
    bit                  run_on;
    colour_t             pending_duty_q[$];
    int                  mismatches;
    int                  checked;
    int                  accepted;

    function new();
      bright_pct = BRIGHT_MAX;
      out_en     = 1'b1;
      invert     = 1'b0;
      mode       = ST_OFF;
      step_count = 0;
      run_on     = 1'b0;
      mismatches = 0;
      checked    = 0;
      accepted   = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_BRIGHT: bright_pct = value[BRIGHT_W-1:0];
        REG_ENABLE: out_en = value[0];
        REG_INVERT: invert = value[0];
        default: ;
      endcase
    endfunction

    function bit animated(logic [3:0] code);
      return (code >= ST_LISTEN) && (code <= ST_OTA);
    endfunction

    // Sine of one full turn over per, in signed Q30, from the reduced
    // quarter wave and an odd polynomial with truncating products.
    function longint wave_q30(longint m, longint per);
      longint quad;
      longint rem;
      longint frac;
      longint f2;
      longint acc;
      quad = (4 * m) / per;
      rem  = (4 * m) % per;
      frac = (rem << 30) / per;
      if (quad % 2 == 1) frac = Q30_ONE - frac;
      f2  = (frac * frac) >> 30;
      acc = K11;
      acc = K9 - ((acc * f2) >> 30);
      acc = K7 - ((acc * f2) >> 30);
      acc = K5 - ((acc * f2) >> 30);
      acc = K3 - ((acc * f2) >> 30);
      acc = K1 - ((acc * f2) >> 30);
      acc = (acc * frac) >> 30;
      return (quad >= 2) ? -acc : acc;
    endfunction

    function logic [7:0] shade(longint s, longint base, longint swing, longint full);
      longint num;
      longint v;
      num = base * Q30_ONE + swing * s;
      if (num < 0) num = 0;
      v = (num * full) / (100 * Q30_ONE);
      if (v > full) v = full;
      return v[7:0];
    endfunction

    function logic [7:0] scale_chan(logic [7:0] c, int unsigned pct);
      logic [7:0] v;
      v = 8'((c * pct) / 100);
      return invert ? 8'd255 - v : v;
    endfunction

    // Disabled output lets only black through.
    function void queue_duty(colour_t c);
      int unsigned pct;
      colour_t     d;
      pct = (bright_pct > BRIGHT_MAX) ? BRIGHT_MAX : bright_pct;
      if (!out_en && c != COL_BLACK) return;
      d.r = scale_chan(c.r, pct);
      d.g = scale_chan(c.g, pct);
      d.b = scale_chan(c.b, pct);
      pending_duty_q.push_back(d);
    endfunction

    // Colour of the current effect at its present time, then one step on.
    function void tick_step();
      int unsigned t;
      longint      s;
      colour_t     c;
      t = (step_count * STEP_MS) % WRAP_MS;
      c = COL_BLACK;
      case (mode)
        ST_LISTEN: c.b = shade(wave_q30(t % LISTEN_PER_MS, LISTEN_PER_MS), 65, 35, 255);
        ST_PROCESS: c = ((t / PROC_HALF_MS) % 2 == 0) ? COL_PROC_HI : COL_PROC_LO;
        ST_SPEAK: begin
          c.g = shade(wave_q30(t % SPEAK_PER_MS, SPEAK_PER_MS), 65, 35, 255);
          c.b = c.g;
        end
        ST_ERROR: if ((t / ERROR_HALF_MS) % 2 == 0) c = COL_ERROR;
        ST_CONNECT: begin
          s   = wave_q30(t % CONNECT_PER_MS, CONNECT_PER_MS);
          c.r = shade(s, 60, 40, 180);
          c.b = shade(s, 60, 40, 255);
        end
        default: begin
          c.r = shade(wave_q30(t % SPEAK_PER_MS, SPEAK_PER_MS), 60, 40, 255);
          c.g = c.r;
          c.b = c.r;
        end
      endcase
      step_count = (step_count + 1) % WRAP_MS;
      if ((step_count * STEP_MS) % WRAP_MS == 0) step_count = 0;
      queue_duty(c);
    endfunction

    function void note_item(logic [1:0] func, logic [3:0] code, colour_t custom);
      logic [3:0] prev;
      accepted++;
      case (func)
        FUNC_TICK: if (run_on && animated(mode)) tick_step();
        FUNC_STATUS: begin
          prev = mode;
          mode = code;
          if (!animated(code) && animated(prev)) run_on = 1'b0;
          if (!out_en) begin
            queue_duty(COL_BLACK);
          end else if (code == ST_OFF) begin
            run_on = 1'b0;
            queue_duty(COL_BLACK);
          end else if (code == ST_BOOT) begin
            queue_duty(COL_BOOT);
          end else if (code == ST_IDLE) begin
            queue_duty(COL_IDLE);
          end else if (animated(code) && !animated(prev) && !run_on) begin
            run_on     = 1'b1;
            step_count = 0;
          end
        end
        FUNC_CUSTOM: begin
          run_on = 1'b0;
          mode   = ST_OFF;
          queue_duty(custom);
        end
        default: ;
      endcase
    endfunction

    function void check_result(colour_t got);
      colour_t want;
      checked++;
      if (pending_duty_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: duty item r=%0d g=%0d b=%0d arrived with none outstanding",
                   got.r, got.g, got.b);
        return;
      end
      want = pending_duty_q.pop_front();
      if (want.r !== got.r || want.g !== got.g || want.b !== got.b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: duty mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.r, want.g, want.b, got.r, got.g, got.b);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rsee_item_if   item_if ();
  rsee_result_if result_if ();

  led_duty_tracker tracker;
  bit              idling;
  bit              hold_req;
  int              work_items;
  int              settings_used;
  int              cycle_count;

  rgb_status_effect_engine_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Global watchdog. The slowest legal run is far below this limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Both handshakes are sampled at the clock edge, before any update that the
  // edge itself causes, so the monitor sees exactly what the block saw.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (item_if.valid && item_if.ready)
        tracker.note_item(item_if.func, item_if.status_code,
                          '{r: item_if.red_in, g: item_if.green_in, b: item_if.blue_in});
      if (result_if.valid && result_if.ready)
        tracker.check_result('{r: result_if.red_duty, g: result_if.green_duty,
                               b: result_if.blue_duty});
    end
  end

  // Result side. It stalls in short random bursts while idling is allowed and
  // once for a long stretch on request, which backs the block up to its input.
  initial begin : result_sink
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        result_if.ready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns once it has been taken. A random gap may come
  // first; valid stays high between items sent back to back.
  task automatic push_item(logic [1:0] func, logic [3:0] code,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (idling && $urandom_range(0, 4) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.func        <= func;
    item_if.status_code <= code;
    item_if.red_in      <= r;
    item_if.green_in    <= g;
    item_if.blue_in     <= b;
    if (func != FUNC_NONE) work_items++;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  // The fields a command does not use still carry random bits.
  task automatic send_tick();
    push_item(FUNC_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_status(logic [3:0] code);
    push_item(FUNC_STATUS, code, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_custom(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    push_item(FUNC_CUSTOM, 4'($urandom), r, g, b);
  endtask

  // Colour channel biased toward the ends of its range.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Static or unknown status code, never one of the effects.
  function automatic logic [3:0] pick_plain_code();
    if ($urandom_range(0, 2) == 0) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(ST_OFF, ST_IDLE));
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Registers change only with the block empty. The first edge lets the
  // monitor note the item taken at the edge just passed. Items that give no
  // result may still be in flight after the last duty item, so the task waits
  // on after it.
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_duty_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(int pct, bit en, bit inv);
    drain();
    apb_write(REG_BRIGHT, DATA_W'(pct));
    apb_write(REG_ENABLE, DATA_W'(en));
    apb_write(REG_INVERT, DATA_W'(inv));
    settings_used++;
  endtask

  // One random episode. Most are effect runs with ticks, sometimes switched
  // to another effect or broken off by a static status or a custom colour.
  // The rest are plain statuses, custom colours, stray ticks and unused
  // commands. A nonzero long_ticks forces one long run past the step wrap.
  task automatic run_episode(int long_ticks);
    int kind;
    int n;
    kind = (long_ticks > 0) ? 0 : $urandom_range(0, 99);
    if (kind < 60) begin
      send_status(4'($urandom_range(ST_LISTEN, ST_OTA)));
      n = (long_ticks > 0) ? long_ticks : $urandom_range(1, 40);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0)
          send_status(4'($urandom_range(ST_LISTEN, ST_OTA)));
        else if (long_ticks == 0 && $urandom_range(0, 39) == 0)
          send_custom(pick_level(), pick_level(), pick_level());
        else if (long_ticks == 0 && $urandom_range(0, 39) == 0)
          send_status(pick_plain_code());
        else
          send_tick();
      end
    end else if (kind < 75) begin
      send_status(pick_plain_code());
    end else if (kind < 87) begin
      send_custom(pick_level(), pick_level(), pick_level());
    end else if (kind < 95) begin
      send_tick();
    end else begin
      push_item(FUNC_NONE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_phase(int count, bit quiet);
    int target;
    target = work_items + count;
    while (work_items < target) begin
      idling = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      run_episode(0);
    end
  endtask

  initial begin : stimulus
    tracker       = new();
    cycle_count   = 0;
    work_items    = 0;
    settings_used = 0;
    idling        = 1'b1;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    item_if.valid       = 1'b0;
    item_if.func        = FUNC_TICK;
    item_if.status_code = ST_OFF;
    item_if.red_in      = '0;
    item_if.green_in    = '0;
    item_if.blue_in     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_setting(100, 1'b1, 1'b0);

    // Directed part: a tick with no effect running, each static status,
    // extreme custom colours, every effect entered and ticked, effect to
    // effect changes that keep the run, a custom colour that ends a run,
    // an unknown status and the unused command.
    send_tick();
    send_status(ST_OFF);
    send_status(ST_BOOT);
    send_status(ST_IDLE);
    send_custom(8'hFF, 8'hFF, 8'hFF);
    send_custom(8'h00, 8'h00, 8'h00);
    send_custom(8'h5A, 8'hA5, 8'hC3);
    send_status(ST_LISTEN);
    send_tick();
    send_tick();
    send_status(ST_PROCESS);
    send_tick();
    send_status(ST_SPEAK);
    send_tick();
    send_status(ST_ERROR);
    send_tick();
    send_status(ST_CONNECT);
    send_tick();
    send_status(ST_OTA);
    send_tick();
    send_custom(8'h12, 8'h34, 8'h56);
    send_tick();
    send_status(ST_OTA);
    send_status(4'hF);
    push_item(FUNC_NONE, 4'hF, 8'hFF, 8'hFF, 8'hFF);

    // Long output hold-off while custom colours keep coming: the queue fills
    // and the input has to stall until the output drains again.
    hold_req = 1'b1;
    repeat (16) send_custom(8'($urandom_range(1, 255)), pick_level(), pick_level());

    // One effect run long enough to cross the wrap of the effect time.
    run_episode(310);
    random_phase(40, 1'b0);

    apply_setting(0, 1'b1, 1'b1);
    random_phase(70, 1'b0);
    apply_setting(127, 1'b0, 1'b0);
    random_phase(70, 1'b0);
    apply_setting(1, 1'b1, 1'b1);
    random_phase(70, 1'b0);
    apply_setting($urandom_range(0, 127), 1'($urandom), 1'($urandom));
    random_phase(70, 1'b0);
    // Last part runs without any idling on either side.
    idling = 1'b0;
    apply_setting(57, 1'b1, 1'b0);
    random_phase(70, 1'b1);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d items accepted, %0d duty items checked, %0d mismatches,",
             tracker.accepted, tracker.checked, tracker.mismatches);
    $display("%0d left over; %0d register settings, all status codes, a run past the wrap, %0d-cycle stall",
             tracker.pending_duty_q.size(), settings_used, HOLD_CYCLES);
    if (tracker.mismatches == 0 && tracker.pending_duty_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rsee_pkg.sv
rtl/rsee_if.sv
rtl/rsee_front.sv
rtl/rsee_queue.sv
rtl/rsee_back.sv
rtl/rgb_status_effect_engine_core.sv
rtl/rsee_checker.sv
dv/rgb_status_effect_engine_core_test.sv
